// ----- rtl/frame_history_ring_tracker_macros.svh -----
// Assertion helpers used by the frame history ring tracker RTL.
`ifndef FRAME_HISTORY_RING_TRACKER_MACROS_SVH
`define FRAME_HISTORY_RING_TRACKER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FHRT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FHRT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/fhrt_pkg.sv -----
package fhrt_pkg;

  localparam int CFG_W   = 5;
  localparam int IDX_W   = 64;
  localparam int CNT_W   = 5;
  localparam int LAYER_W = 4;
  localparam int CFGA_W  = 2;

  typedef enum logic [1:0] {
    OP_BEGIN   = 2'd0,
    OP_CAPTURE = 2'd1,
    OP_DROP    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  localparam logic [CFGA_W-1:0] CFG_COLOUR_DEPTH     = 2'd0;
  localparam logic [CFGA_W-1:0] CFG_HISTORY_CAPACITY = 2'd1;
  localparam logic [CFGA_W-1:0] CFG_FRAMES_NEEDED    = 2'd2;

  // Ring bookkeeping; the pointers hold any clipped depth below 32
  typedef struct packed {
    logic             have_last;
    logic [IDX_W-1:0] last_index;
    logic [CNT_W-1:0] valid_count;
    logic [CNT_W-1:0] valid_at_start;
    logic [CNT_W-1:0] write_ptr;
    logic [CNT_W-1:0] write_at_start;
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0]   frames_valid;
    logic [LAYER_W-1:0] write_layer;
    logic               stalled;
    logic               repeat_frame;
    logic               history_dropped;
    logic               captured;
  } res_t;

  // Clipped configuration seen by the event logic
  typedef struct packed {
    logic [CFG_W-1:0] colour_depth;
    logic [CFG_W-1:0] history_capacity;
    logic [CFG_W-1:0] frames_needed;
  } cfg_t;

endpackage

// ----- rtl/fhrt_in_if.sv -----
interface fhrt_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  opcode;
  logic [fhrt_pkg::IDX_W-1:0]  frame_index;

  modport source (output valid, output opcode, output frame_index, input ready);
  modport sink   (input valid, input opcode, input frame_index, output ready);
endinterface

// ----- rtl/fhrt_out_if.sv -----
interface fhrt_out_if;
  logic                          valid;
  logic                          ready;
  logic [fhrt_pkg::CNT_W-1:0]    frames_valid;
  logic [fhrt_pkg::LAYER_W-1:0]  write_layer;
  logic                          stalled;
  logic                          repeat_frame;
  logic                          history_dropped;
  logic                          captured;

  modport source (output valid, output frames_valid, output write_layer, output stalled,
                  output repeat_frame, output history_dropped, output captured,
                  input ready);
  modport sink   (input valid, input frames_valid, input write_layer, input stalled,
                  input repeat_frame, input history_dropped, input captured,
                  output ready);
endinterface

// ----- rtl/fhrt_step.sv -----
module fhrt_step (
  input  fhrt_pkg::op_t                 op,
  input  logic [fhrt_pkg::IDX_W-1:0]    frame_index,
  input  fhrt_pkg::cfg_t                cfg,
  input  fhrt_pkg::state_t              cur,
  output fhrt_pkg::state_t              nxt,
  output fhrt_pkg::res_t                res
);

  logic                         is_repeat;
  logic                         is_gap;
  logic [fhrt_pkg::CNT_W-1:0]   cap_layer;
  logic [fhrt_pkg::CNT_W-1:0]   cap_next;
  logic                         rep;
  logic                         dropped;
  logic                         cap_done;

  // Compare against the last started index and its successor
  assign is_repeat = cur.have_last && (frame_index == cur.last_index);
  assign is_gap    = cur.have_last && (frame_index != (cur.last_index + 64'd1));

  // Capture layer: restart from zero when the pointer sits at or beyond the depth
  assign cap_layer = (cur.write_ptr < cfg.colour_depth) ? cur.write_ptr : '0;
  assign cap_next  = ((cap_layer + 5'd1) >= cfg.colour_depth) ? '0 : cap_layer + 5'd1;

  // Apply the event to the ring state
  always_comb begin
    nxt      = cur;
    rep      = 1'b0;
    dropped  = 1'b0;
    cap_done = 1'b0;
    case (op)
      fhrt_pkg::OP_BEGIN: begin
        if (is_repeat) begin
          rep             = 1'b1;
          nxt.valid_count = cur.valid_at_start;
          nxt.write_ptr   = cur.write_at_start;
        end else begin
          if (is_gap) begin
            nxt.valid_count = '0;
            dropped         = 1'b1;
          end
          nxt.valid_at_start = is_gap ? '0 : cur.valid_count;
          nxt.write_at_start = cur.write_ptr;
        end
        nxt.last_index = frame_index;
        nxt.have_last  = 1'b1;
      end
      fhrt_pkg::OP_CAPTURE: begin
        if (cfg.colour_depth != '0) begin
          nxt.write_ptr = cap_next;
          if (cur.valid_count < cfg.colour_depth) begin
            nxt.valid_count = cur.valid_count + 5'd1;
          end
          cap_done = 1'b1;
        end
      end
      fhrt_pkg::OP_DROP: begin
        nxt.valid_count    = '0;
        nxt.valid_at_start = '0;
        nxt.have_last      = 1'b0;
        dropped            = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Build the status reported with the event
  always_comb begin
    res.frames_valid    = (nxt.valid_count < cfg.history_capacity) ?
                          nxt.valid_count : cfg.history_capacity;
    res.write_layer     = nxt.write_ptr[fhrt_pkg::LAYER_W-1:0];
    res.stalled         = cfg.frames_needed > cfg.history_capacity;
    res.repeat_frame    = rep;
    res.history_dropped = dropped;
    res.captured        = cap_done;
  end

endmodule

// ----- rtl/frame_history_ring_tracker.sv -----
// Channel  | Direction | Handshake   | Payload
// in_chan  | sink      | valid/ready | opcode, frame_index
// out_chan | source    | valid/ready | frames_valid, write_layer, stalled, event flags
// cfg      | write     | cfg_we      | cfg_index, cfg_data
//
// One event per cycle sustained while results are taken.
// Stage one registers the event, stage two applies it to the ring state and the result
// register. Synchronous active-low reset clears the ring state, the configuration and
// both valid flags. A stalled result holds both stages; the input is still taken while
// the event register is empty.
`include "frame_history_ring_tracker_macros.svh"

module frame_history_ring_tracker #(
  parameter int MAX_FRAMES = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  fhrt_in_if.sink                          in_chan,
  fhrt_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [fhrt_pkg::CFGA_W-1:0]      cfg_index,
  input  logic [fhrt_pkg::CFG_W-1:0]       cfg_data
);

  localparam int CFG_MAX  = (1 << fhrt_pkg::CFG_W) - 1;
  localparam int CLIP_MAX = (MAX_FRAMES > CFG_MAX) ? CFG_MAX : MAX_FRAMES;

  fhrt_pkg::cfg_t                 cfg_r;
  logic [fhrt_pkg::CFG_W-1:0]     cfg_clipped;

  logic                           s1_valid_r;
  fhrt_pkg::op_t                  s1_op_r;
  logic [fhrt_pkg::IDX_W-1:0]     s1_idx_r;

  fhrt_pkg::state_t               state_r;
  fhrt_pkg::state_t               state_nxt;
  fhrt_pkg::res_t                 res_r;
  fhrt_pkg::res_t                 res_nxt;
  logic                           out_valid_r;

  logic                           advance;
  logic                           in_xfer;

  // Clip the written value to the ring limit
  assign cfg_clipped = (cfg_data > fhrt_pkg::CFG_W'(CLIP_MAX)) ?
                       fhrt_pkg::CFG_W'(CLIP_MAX) : cfg_data;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fhrt_pkg::CFG_COLOUR_DEPTH:     cfg_r.colour_depth     <= cfg_clipped;
        fhrt_pkg::CFG_HISTORY_CAPACITY: cfg_r.history_capacity <= cfg_clipped;
        fhrt_pkg::CFG_FRAMES_NEEDED:    cfg_r.frames_needed    <= cfg_clipped;
        default: begin
        end
      endcase
    end
  end

  // Advance the pipe when the result register is free or being taken
  assign advance       = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !s1_valid_r || advance;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  // Event register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r  <= fhrt_pkg::op_t'(in_chan.opcode);
      s1_idx_r <= in_chan.frame_index;
    end
  end

  fhrt_step u_step (
    .op          (s1_op_r),
    .frame_index (s1_idx_r),
    .cfg         (cfg_r),
    .cur         (state_r),
    .nxt         (state_nxt),
    .res         (res_nxt)
  );

  // Commit the event to the ring state and load the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  // Drive the result channel
  assign out_chan.valid           = out_valid_r;
  assign out_chan.frames_valid    = res_r.frames_valid;
  assign out_chan.write_layer     = res_r.write_layer;
  assign out_chan.stalled         = res_r.stalled;
  assign out_chan.repeat_frame    = res_r.repeat_frame;
  assign out_chan.history_dropped = res_r.history_dropped;
  assign out_chan.captured        = res_r.captured;

  `FHRT_ASSERT_IMP(a_count_in_range, 1'b1, state_r.valid_count <= fhrt_pkg::CNT_W'(CLIP_MAX), "valid count beyond ring limit")
  `FHRT_ASSERT_IMP(a_shown_capped, out_valid_r, res_r.frames_valid <= cfg_r.history_capacity, "reported count above capacity")
  `FHRT_ASSERT_IMP(a_flags_exclusive, out_valid_r, !(res_r.repeat_frame && res_r.history_dropped) && !(res_r.captured && (res_r.repeat_frame || res_r.history_dropped)), "conflicting event flags")
  `FHRT_ASSERT_NXT(a_event_reaches_out, s1_valid_r && advance, out_valid_r, "event lost between stages")
  `FHRT_ASSERT_NXT(a_state_holds, !(s1_valid_r && advance), $stable(state_r), "ring state moved without an event")

endmodule

// ----- dv/frame_history_ring_tracker_checker.sv -----
module frame_history_ring_tracker_checker
  import fhrt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  fhrt_in_if                  in_chan,
  fhrt_out_if                 out_chan,
  input  logic                cfg_we,
  input  logic [CFGA_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  output int                  fail_count,
  output int                  results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_FRAMES = 16;

  // Register copies as written
  logic [CFG_W-1:0] depth_reg;
  logic [CFG_W-1:0] capacity_reg;
  logic [CFG_W-1:0] needed_reg;

  // Ring bookkeeping
  bit               have_last;
  logic [IDX_W-1:0] last_index;
  logic [CNT_W-1:0] valid_count;
  logic [CNT_W-1:0] valid_at_start;
  logic [CNT_W-1:0] write_ptr;
  logic [CNT_W-1:0] write_at_start;

  res_t expected_status[$];

  function automatic logic [CNT_W-1:0] clip_frames(logic [CFG_W-1:0] v);
    return (v > MAX_FRAMES) ? CNT_W'(MAX_FRAMES) : v;
  endfunction

  // Apply one event to the ring bookkeeping and return the status it reports
  function automatic res_t apply_event(op_t op, logic [IDX_W-1:0] idx);
    res_t             r;
    logic [CNT_W-1:0] depth;
    logic [CNT_W-1:0] capacity;
    logic [CNT_W-1:0] needed;
    logic [CNT_W-1:0] cur;
    logic [CNT_W-1:0] nxt;
    r        = '0;
    capacity = clip_frames(capacity_reg);
    needed   = clip_frames(needed_reg);
    case (op)
      OP_BEGIN: begin
        if (have_last && idx == last_index) begin
          r.repeat_frame = 1'b1;
          valid_count    = valid_at_start;
          write_ptr      = write_at_start;
        end else begin
          // anything but the successor index loses the history
          if (have_last && idx != last_index + 64'd1) begin
            valid_count       = '0;
            r.history_dropped = 1'b1;
          end
          valid_at_start = valid_count;
          write_at_start = write_ptr;
        end
        last_index = idx;
        have_last  = 1'b1;
      end
      OP_CAPTURE: begin
        depth = clip_frames(depth_reg);
        if (depth != 0) begin
          // a pointer left beyond a lowered depth restarts from layer 0
          cur = (write_ptr < depth) ? write_ptr : '0;
          nxt = cur + 1'b1;
          if (nxt >= depth) nxt = '0;
          write_ptr = nxt;
          if (valid_count < depth) valid_count = valid_count + 1'b1;
          r.captured = 1'b1;
        end
      end
      OP_DROP: begin
        valid_count       = '0;
        valid_at_start    = '0;
        have_last         = 1'b0;
        r.history_dropped = 1'b1;
      end
      default: ;
    endcase
    r.frames_valid = (valid_count < capacity) ? valid_count : capacity;
    r.write_layer  = write_ptr[LAYER_W-1:0];
    r.stalled      = (needed > capacity);
    return r;
  endfunction

  task automatic report_mismatch(string field, int exp_val, int got_val);
    $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, exp_val, got_val);
    fail_count++;
  endtask

  always @(posedge clk) begin
    res_t exp_r;
    res_t predicted;
    if (!rst_n) begin
      depth_reg      = '0;
      capacity_reg   = '0;
      needed_reg     = '0;
      have_last      = 1'b0;
      last_index     = '0;
      valid_count    = '0;
      valid_at_start = '0;
      write_ptr      = '0;
      write_at_start = '0;
      expected_status.delete();
    end else begin
      // compare the result transfer against the oldest expectation
      if (out_chan.valid && out_chan.ready) begin
        if (expected_status.size() == 0) begin
          $display("%0t: result transfer with no event outstanding", $realtime);
          fail_count++;
        end else begin
          exp_r = expected_status.pop_front();
          if (out_chan.frames_valid !== exp_r.frames_valid)
            report_mismatch("frames_valid", int'(exp_r.frames_valid),
                            int'(out_chan.frames_valid));
          if (out_chan.write_layer !== exp_r.write_layer)
            report_mismatch("write_layer", int'(exp_r.write_layer),
                            int'(out_chan.write_layer));
          if (out_chan.stalled !== exp_r.stalled)
            report_mismatch("stalled", int'(exp_r.stalled), int'(out_chan.stalled));
          if (out_chan.repeat_frame !== exp_r.repeat_frame)
            report_mismatch("repeat_frame", int'(exp_r.repeat_frame),
                            int'(out_chan.repeat_frame));
          if (out_chan.history_dropped !== exp_r.history_dropped)
            report_mismatch("history_dropped", int'(exp_r.history_dropped),
                            int'(out_chan.history_dropped));
          if (out_chan.captured !== exp_r.captured)
            report_mismatch("captured", int'(exp_r.captured), int'(out_chan.captured));
        end
      end
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_COLOUR_DEPTH:     depth_reg    = cfg_data;
          CFG_HISTORY_CAPACITY: capacity_reg = cfg_data;
          CFG_FRAMES_NEEDED:    needed_reg   = cfg_data;
          default: ;
        endcase
      end
      // predict the event transfer and queue it behind the older ones
      if (in_chan.valid && in_chan.ready) begin
        predicted       = apply_event(op_t'(in_chan.opcode), in_chan.frame_index);
        expected_status = {expected_status, predicted};
      end
    end
    results_owed = expected_status.size();
  end

endmodule

// ----- dv/frame_history_ring_tracker_tb.sv -----
module frame_history_ring_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fhrt_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFGA_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  int                fail_total;
  int                results_owed;
  bit                idle_on;
  logic [IDX_W-1:0]  frame_cursor;
  int                events_sent;

  fhrt_in_if  in_chan ();
  fhrt_out_if out_chan ();

  frame_history_ring_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  frame_history_ring_tracker_checker status_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .out_chan     (out_chan),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_total),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop
  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

  // Result side: stall at random while idling is on
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= !(idle_on && $urandom_range(99) < 11);
    end
  end

  // Offer one event and hold it until the transfer; returns at a falling edge
  task automatic send_event(op_t op, logic [IDX_W-1:0] idx);
    while (idle_on && $urandom_range(99) < 11) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.opcode      <= op;
    in_chan.frame_index <= idx;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
    if (op != OP_NONE) events_sent++;
  endtask

  // Drop valid and wait until every result has come back
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_chan.valid <= 1'b0;
    while (results_owed != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFGA_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_ring(int depth, int capacity, int needed);
    wait_drained();
    write_reg(CFG_COLOUR_DEPTH, CFG_W'(depth));
    write_reg(CFG_HISTORY_CAPACITY, CFG_W'(capacity));
    write_reg(CFG_FRAMES_NEEDED, CFG_W'(needed));
  endtask

  // Mostly consecutive frames with a few captures each, plus repeats, jumps and noise
  task automatic run_frames(int n);
    int goal;
    int pick;
    goal = events_sent + n;
    while (events_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_event(OP_BEGIN, frame_cursor);
      end else if (pick < 18) begin
        frame_cursor = {$urandom, $urandom};
        send_event(OP_BEGIN, frame_cursor);
      end else if (pick < 21) begin
        // land next to the index wrap
        frame_cursor = '1 - IDX_W'($urandom_range(2));
        send_event(OP_BEGIN, frame_cursor);
      end else if (pick < 26) begin
        send_event(OP_DROP, {$urandom, $urandom});
      end else if (pick < 29) begin
        send_event(OP_NONE, {$urandom, $urandom});
      end else begin
        frame_cursor = frame_cursor + 1'b1;
        send_event(OP_BEGIN, frame_cursor);
      end
      repeat ($urandom_range(0, 4)) send_event(OP_CAPTURE, {$urandom, $urandom});
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    in_chan.valid       = 1'b0;
    in_chan.opcode      = OP_BEGIN;
    in_chan.frame_index = '0;
    idle_on             = 1'b1;
    frame_cursor        = '0;
    events_sent         = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Disabled ring, unused opcode and drop straight out of reset
    send_event(OP_CAPTURE, '0);
    send_event(OP_NONE, '1);
    send_event(OP_DROP, '0);

    // Full ring: wrap of the index, repeats and a discontinuity
    set_ring(16, 16, 0);
    send_event(OP_BEGIN, '1);
    repeat (3) send_event(OP_CAPTURE, '0);
    send_event(OP_BEGIN, '1);
    send_event(OP_CAPTURE, '1);
    send_event(OP_BEGIN, '0);
    repeat (3) send_event(OP_CAPTURE, '0);
    send_event(OP_BEGIN, 64'h5555_5555_5555_5555);
    send_event(OP_BEGIN, 64'h5555_5555_5555_5555);
    send_event(OP_CAPTURE, '0);
    send_event(OP_DROP, 64'hAAAA_AAAA_AAAA_AAAA);
    send_event(OP_NONE, 64'hAAAA_AAAA_AAAA_AAAA);
    send_event(OP_CAPTURE, '0);

    // Lower the depth below the write layer, and stall on capacity
    set_ring(3, 2, 5);
    send_event(OP_CAPTURE, '0);
    send_event(OP_BEGIN, 64'd7);
    repeat (3) send_event(OP_CAPTURE, '0);
    send_event(OP_BEGIN, 64'd7);

    // Random phases over a range of settings
    set_ring(16, 16, 0);
    run_frames(60);
    set_ring(16, 8, 12);
    run_frames(60);
    set_ring(1, 1, 0);
    run_frames(50);
    set_ring(4, 16, 3);
    run_frames(55);
    // long stretch with no idling on either side
    idle_on = 1'b0;
    set_ring(16, 16, 16);
    run_frames(70);
    idle_on = 1'b1;
    // values above the ring limit are clipped
    set_ring(31, 31, 31);
    run_frames(50);
    set_ring(2, 0, 16);
    run_frames(40);
    set_ring(0, 5, 5);
    run_frames(30);
    repeat (3) begin
      set_ring($urandom_range(0, 16), $urandom_range(0, 16), $urandom_range(0, 16));
      run_frames(30);
    end

    wait_drained();
    if (fail_total == 0 && results_owed == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
